FILE: sv/hse_pkg.sv
// Package for the heap sort engine: queue item type, value and swap counter types.
// Shared by hse_front, hse_back and the top level; depends on nothing.
package hse_pkg;

   localparam int VALUE_W     = 32;
   localparam int SWAP_W      = 10;
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [SWAP_W-1:0]         swap_type;

   localparam swap_type SWAP_MAX = 10'd1023;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      drop;
   } hse_item_type;

endpackage

FILE: sv/hse_front.sv
// Front end of the heap sort engine: accepts request words, tags those beyond capacity
// as dropped and holds them in a short queue for the back end. Depends on hse_pkg.
module hse_front #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hse_pkg::value_type   req_value,
   input  logic                 req_last,
   output logic                 item_valid,
   output hse_pkg::hse_item_type item,
   input  logic                 item_pop
);
   import hse_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = $clog2(QUEUE_DEPTH);

   hse_item_type      queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       fill_ff, fill_in;
   logic [CW-1:0]     set_cnt_ff, set_cnt_in;
   logic              accept;
   logic              drop;
   hse_item_type      new_item;

   assign req_stall  = (fill_ff == (PW+1)'(QUEUE_DEPTH));
   assign accept     = req_valid && !req_stall;
   assign drop       = (set_cnt_ff == CW'(CAPACITY));
   assign item_valid = (fill_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.value = req_value;
      new_item.last  = req_last;
      new_item.drop  = drop;
      wr_ptr_in  = accept ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in  = item_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in    = fill_ff;
      if (accept && !item_pop) begin
         fill_in = fill_ff + (PW+1)'(1);
      end else if (!accept && item_pop) begin
         fill_in = fill_ff - (PW+1)'(1);
      end
      set_cnt_in = set_cnt_ff;
      if (accept) begin
         if (req_last) begin
            set_cnt_in = '0;
         end else if (!drop) begin
            set_cnt_in = set_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         set_cnt_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
         set_cnt_ff <= set_cnt_in;
      end
   end

endmodule

FILE: sv/hse_back.sv
// Back end of the heap sort engine: element memory, heap build and extraction sequencer,
// swap counting and the registered response stage. Depends on hse_pkg.
module hse_back #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  hse_pkg::hse_item_type item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hse_pkg::value_type    rsp_sorted_value,
   output logic                  rsp_last_out,
   output hse_pkg::swap_type     rsp_swap_count,
   output logic                  rsp_overflowed
);
   import hse_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_BUILD  = 3'd1;
   localparam logic [2:0] S_KIDS   = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_EXT_RD = 3'd4;
   localparam logic [2:0] S_EXT_SW = 3'd5;
   localparam logic [2:0] S_OUT_RD = 3'd6;
   localparam logic [2:0] S_OUT_WR = 3'd7;

   value_type       mem [CAPACITY];
   value_type       rd_a_ff, rd_b_ff;
   logic [AW-1:0]   rd_addr_a, rd_addr_b, wr_addr;
   value_type       wr_data;
   logic            mem_we;

   logic [2:0]      state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [CW-1:0]   k_ff, k_in;
   logic [CW-1:0]   size_ff, size_in;
   logic [AW-1:0]   node_ff, node_in;
   value_type       cur_ff, cur_in;
   logic            load_ff, load_in;
   logic            ext_ff, ext_in;
   swap_type        swap_ff, swap_in;
   logic            ovf_ff, ovf_in;
   logic            rsp_valid_ff, rsp_valid_in;
   value_type       rsp_value_ff, rsp_value_in;
   logic            rsp_last_ff, rsp_last_in;
   swap_type        rsp_swap_ff, rsp_swap_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   logic [IW-1:0]   lc, rc, size_ext;
   logic            lc_ok, rc_ok, take_left, take_right, moved;
   value_type       best_l, best;
   logic [AW-1:0]   top_idx;
   logic [CW-1:0]   k_dec, n_load;
   logic            out_free, fin;
   swap_type        swap_inc;

   assign lc         = {1'b0, node_ff, 1'b1};
   assign rc         = lc + IW'(1);
   assign size_ext   = IW'(size_ff);
   assign lc_ok      = (lc < size_ext);
   assign rc_ok      = (rc < size_ext);
   assign take_left  = lc_ok && (rd_a_ff > cur_ff);
   assign best_l     = take_left ? rd_a_ff : cur_ff;
   assign take_right = rc_ok && (rd_b_ff > best_l);
   assign best       = take_right ? rd_b_ff : best_l;
   assign top_idx    = take_right ? rc[AW-1:0] : lc[AW-1:0];
   assign moved      = take_left || take_right;
   assign k_dec      = k_ff - CW'(1);
   assign n_load     = item.drop ? cnt_ff : cnt_ff + CW'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fin        = (k_ff + CW'(1) == n_ff);
   assign swap_inc   = (swap_ff == SWAP_MAX) ? swap_ff : swap_ff + SWAP_W'(1);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_swap_count   = rsp_swap_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      size_in      = size_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      load_in      = load_ff;
      ext_in       = ext_ff;
      swap_in      = swap_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_swap_in  = rsp_swap_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cur_ff;
      rd_addr_a    = k_ff[AW-1:0];
      rd_addr_b    = rc[AW-1:0];
      item_pop     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            item_pop = item_valid;
            if (item_valid) begin
               if (!item.drop) begin
                  mem_we  = 1'b1;
                  wr_addr = cnt_ff[AW-1:0];
                  wr_data = item.value;
                  cnt_in  = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (item.last) begin
                  n_in     = n_load;
                  k_in     = n_load >> 1;
                  ext_in   = 1'b0;
                  state_in = S_BUILD;
               end
            end
         end
         S_BUILD: begin
            if (k_ff == '0) begin
               ext_in   = 1'b1;
               k_in     = n_ff;
               state_in = S_EXT_RD;
            end else begin
               rd_addr_a = k_dec[AW-1:0];
               node_in   = k_dec[AW-1:0];
               size_in   = n_ff;
               k_in      = k_dec;
               load_in   = 1'b1;
               state_in  = S_KIDS;
            end
         end
         S_KIDS: begin
            if (load_ff) begin
               cur_in = rd_a_ff;
            end
            rd_addr_a = lc[AW-1:0];
            rd_addr_b = rc[AW-1:0];
            load_in   = 1'b0;
            state_in  = S_CMP;
         end
         S_CMP: begin
            mem_we  = 1'b1;
            wr_addr = node_ff;
            if (moved) begin
               wr_data  = best;
               node_in  = top_idx;
               swap_in  = swap_inc;
               state_in = S_KIDS;
            end else begin
               wr_data  = cur_ff;
               state_in = ext_ff ? S_EXT_RD : S_BUILD;
            end
         end
         S_EXT_RD: begin
            if (k_ff == '0) begin
               state_in = S_OUT_RD;
            end else begin
               rd_addr_a = '0;
               rd_addr_b = k_dec[AW-1:0];
               state_in  = S_EXT_SW;
            end
         end
         S_EXT_SW: begin
            mem_we   = 1'b1;
            wr_addr  = k_dec[AW-1:0];
            wr_data  = rd_a_ff;
            cur_in   = rd_b_ff;
            node_in  = '0;
            size_in  = k_dec;
            k_in     = k_dec;
            swap_in  = swap_inc;
            load_in  = 1'b0;
            state_in = S_KIDS;
         end
         S_OUT_RD: begin
            rd_addr_a = k_ff[AW-1:0];
            state_in  = S_OUT_WR;
         end
         S_OUT_WR: begin
            rd_addr_a = k_ff[AW-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_a_ff;
               rsp_last_in  = fin;
               rsp_swap_in  = fin ? swap_ff : '0;
               rsp_ovf_in   = fin && ovf_ff;
               if (fin) begin
                  cnt_in   = '0;
                  swap_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      k_ff         <= k_in;
      size_ff      <= size_in;
      node_ff      <= node_in;
      cur_ff       <= cur_in;
      load_ff      <= load_in;
      ext_ff       <= ext_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_swap_ff  <= rsp_swap_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         swap_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         swap_ff      <= swap_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/heap_sort_engine.sv
// Top level of the heap sort engine: joins the front end queue to the sorting back end.
// Depends on hse_pkg, hse_front and hse_back.
//
// Usage: send a set of signed 32-bit words on the req_ channel, the final one with
// req_last high. Up to CAPACITY words are kept; later words of the set are dropped and
// reported through rsp_overflowed on the final result. The sorted set comes back in
// ascending order on the rsp_ channel, rsp_last_out high on its final word, which also
// carries the saturating swap count.
// Words load through a two-word queue, so req_stall stays low while a set streams in.
// Sorting runs on one memory with two registered read ports and one write port: a sift
// step passes S_KIDS then S_CMP, each extraction S_EXT_RD then S_EXT_SW, each node of
// the heap build S_BUILD, and each result S_OUT_RD then S_OUT_WR. Words sent during
// sorting wait in the queue and req_stall rises once it is full.
// A stalled result holds on the rsp_ ports until rsp_stall falls; the sequencer waits.
// Synchronous reset empties the queue, clears the counters and drops any result.
module heap_sort_engine #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  hse_pkg::value_type req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output hse_pkg::value_type rsp_sorted_value,
   output logic               rsp_last_out,
   output hse_pkg::swap_type  rsp_swap_count,
   output logic               rsp_overflowed
);
   import hse_pkg::*;

   logic         item_valid;
   logic         item_pop;
   hse_item_type item;

   hse_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .req_last   (req_last),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   hse_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_swap_count   (rsp_swap_count),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

FILE: sv/hse_checker.sv
// Port-level checks for the heap sort engine, bound to the top level.
// Depends on hse_pkg and heap_sort_engine.
module hse_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input hse_pkg::value_type rsp_sorted_value,
   input logic               rsp_last_out,
   input hse_pkg::swap_type  rsp_swap_count,
   input logic               rsp_overflowed
);
   import hse_pkg::*;

   logic      open_ff, open_in;
   value_type prev_ff, prev_in;

   always_comb begin
      open_in = open_ff;
      prev_in = prev_ff;
      if (rsp_valid && !rsp_stall) begin
         open_in = !rsp_last_out;
         prev_in = rsp_sorted_value;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sorted_value)
         && $stable(rsp_last_out))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_out |-> rsp_swap_count == '0 && !rsp_overflowed)
      else $error("count or overflow shown on a non-final result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out |-> rsp_swap_count != '0)
      else $error("final result reports no swaps");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && open_ff |-> rsp_sorted_value >= prev_ff)
      else $error("results not in ascending order");

endmodule

bind heap_sort_engine hse_checker u_checker (.*);
